### hdl/rk4s_pkg.sv
package rk4s_pkg;

    localparam int DW = 32;
    localparam int FB = 16;
    localparam int APB_AW = 5;
    localparam int PC_W = 7;

    localparam logic [DW-1:0] VMAX = {1'b0, {(DW-1){1'b1}}};
    localparam logic [DW-1:0] VMIN = {1'b1, {(DW-1){1'b0}}};
    localparam logic [DW-1:0] ONE = DW'(1) << FB;

    // Reciprocal of six for a 31-bit dividend: q = (h * SIXTH_M) >> SIXTH_SH.
    localparam logic [31:0] SIXTH_M = 32'd2863311531;
    localparam int SIXTH_SH = 34;

    // Register indexes of the configuration port.
    localparam logic [2:0] CFG_GAIN_A = 3'd0;
    localparam logic [2:0] CFG_GAIN_B = 3'd1;
    localparam logic [2:0] CFG_THRESH = 3'd2;
    localparam logic [2:0] CFG_TAU_X = 3'd3;
    localparam logic [2:0] CFG_TAU_H = 3'd4;
    localparam logic [2:0] CFG_AMP_X = 3'd5;
    localparam logic [2:0] CFG_MU = 3'd6;

    // Operand and destination codes. Codes below 16 are scratch memory slots.
    localparam logic [5:0] R_TH = 6'd0;
    localparam logic [5:0] R_TX = 6'd1;
    localparam logic [5:0] R_DRV = 6'd2;
    localparam logic [5:0] R_K1H = 6'd3;
    localparam logic [5:0] R_K1X = 6'd4;
    localparam logic [5:0] R_K2H = 6'd5;
    localparam logic [5:0] R_K2X = 6'd6;
    localparam logic [5:0] R_K3H = 6'd7;
    localparam logic [5:0] R_K3X = 6'd8;
    localparam logic [5:0] R_DH = 6'd9;
    localparam logic [5:0] R_DX = 6'd10;
    localparam logic [5:0] R_T0 = 6'd11;
    localparam logic [5:0] R_T1 = 6'd12;
    localparam logic [5:0] R_T2 = 6'd13;
    localparam logic [5:0] R_H2 = 6'd14;
    localparam logic [5:0] R_H6 = 6'd15;
    localparam logic [5:0] R_H = 6'd16;
    localparam logic [5:0] R_X = 6'd17;
    localparam logic [5:0] R_THETA = 6'd18;
    localparam logic [5:0] R_SC = 6'd19;
    localparam logic [5:0] R_GA = 6'd20;
    localparam logic [5:0] R_GB = 6'd21;
    localparam logic [5:0] R_IC = 6'd22;
    localparam logic [5:0] R_TAUX = 6'd23;
    localparam logic [5:0] R_TAUH = 6'd24;
    localparam logic [5:0] R_AX = 6'd25;
    localparam logic [5:0] R_MU = 6'd26;
    localparam logic [5:0] R_DS = 6'd27;
    localparam logic [5:0] R_DM = 6'd28;
    localparam logic [5:0] R_DE = 6'd29;
    localparam logic [5:0] R_HS = 6'd30;
    localparam logic [5:0] R_LH = 6'd31;
    localparam logic [5:0] R_LX = 6'd32;
    localparam logic [5:0] R_ONE = 6'd33;
    localparam logic [5:0] R_ZERO = 6'd34;
    localparam logic [5:0] R_TWO = 6'd35;
    localparam logic [5:0] R_SIX = 6'd36;

    localparam logic [PC_W-1:0] PC_LOAD = 7'd42;
    localparam logic [PC_W-1:0] PC_DERIV = 7'd53;
    localparam logic [PC_W-1:0] PC_LAST = 7'd72;

    typedef enum logic [3:0] {
        U_ADD, U_SUB, U_MUL, U_DIV, U_HALF, U_SIXTH, U_SQRT,
        U_GT, U_SEL, U_CALL, U_RET, U_JMP, U_END
    } uop_t;

    typedef struct packed {
        uop_t op;
        logic [5:0] dst;
        logic [5:0] sa;
        logic [5:0] sb;
    } uinstr_t;

    typedef struct packed {
        logic start;
        uop_t op;
    } alu_req_t;

    typedef struct packed {
        logic done;
        logic busy;
    } alu_rsp_t;

    typedef enum logic [2:0] {S_IDLE, S_FETCH, S_OPER, S_WAIT, S_DONE} state_t;

    // Saturate a magnitude with a sign into the signed data range.
    function automatic logic [DW-1:0] sat_mag(input logic [47:0] m, input logic neg);
        logic [DW-1:0] r;
        if (neg) begin
            if (m > 48'(VMIN)) r = VMIN;
            else r = DW'(-m);
        end else begin
            if (m > 48'(VMAX)) r = VMAX;
            else r = m[DW-1:0];
        end
        return r;
    endfunction

    function automatic uinstr_t mk(input uop_t op, input logic [5:0] d,
                                   input logic [5:0] a, input logic [5:0] b);
        uinstr_t r;
        r.op = op;
        r.dst = d;
        r.sa = a;
        r.sb = b;
        return r;
    endfunction

    // Micro-program. The step path starts at 0, the load path at PC_LOAD,
    // and the derivative routine at PC_DERIV is entered by a call.
    function automatic uinstr_t rom(input logic [PC_W-1:0] pc);
        uinstr_t r;
        case (pc)
            7'd0: r = mk(U_HALF, R_H2, R_HS, R_ZERO);
            7'd1: r = mk(U_SIXTH, R_H6, R_HS, R_ZERO);
            7'd2: r = mk(U_ADD, R_TH, R_H, R_ZERO);
            7'd3: r = mk(U_ADD, R_TX, R_X, R_ZERO);
            7'd4: r = mk(U_ADD, R_DRV, R_DS, R_ZERO);
            7'd5: r = mk(U_CALL, R_ZERO, R_ZERO, R_ZERO);
            7'd6: r = mk(U_ADD, R_K1H, R_DH, R_ZERO);
            7'd7: r = mk(U_ADD, R_K1X, R_DX, R_ZERO);
            7'd8: r = mk(U_MUL, R_T0, R_H2, R_DH);
            7'd9: r = mk(U_ADD, R_TH, R_H, R_T0);
            7'd10: r = mk(U_MUL, R_T0, R_H2, R_DX);
            7'd11: r = mk(U_ADD, R_TX, R_X, R_T0);
            7'd12: r = mk(U_ADD, R_DRV, R_DM, R_ZERO);
            7'd13: r = mk(U_CALL, R_ZERO, R_ZERO, R_ZERO);
            7'd14: r = mk(U_ADD, R_K2H, R_DH, R_ZERO);
            7'd15: r = mk(U_ADD, R_K2X, R_DX, R_ZERO);
            7'd16: r = mk(U_MUL, R_T0, R_H2, R_DH);
            7'd17: r = mk(U_ADD, R_TH, R_H, R_T0);
            7'd18: r = mk(U_MUL, R_T0, R_H2, R_DX);
            7'd19: r = mk(U_ADD, R_TX, R_X, R_T0);
            7'd20: r = mk(U_CALL, R_ZERO, R_ZERO, R_ZERO);
            7'd21: r = mk(U_ADD, R_K3H, R_DH, R_ZERO);
            7'd22: r = mk(U_ADD, R_K3X, R_DX, R_ZERO);
            7'd23: r = mk(U_MUL, R_T0, R_HS, R_DH);
            7'd24: r = mk(U_ADD, R_TH, R_H, R_T0);
            7'd25: r = mk(U_MUL, R_T0, R_HS, R_DX);
            7'd26: r = mk(U_ADD, R_TX, R_X, R_T0);
            7'd27: r = mk(U_ADD, R_DRV, R_DE, R_ZERO);
            7'd28: r = mk(U_CALL, R_ZERO, R_ZERO, R_ZERO);
            7'd29: r = mk(U_ADD, R_K3H, R_K3H, R_K2H);
            7'd30: r = mk(U_ADD, R_K3X, R_K3X, R_K2X);
            7'd31: r = mk(U_ADD, R_T0, R_K1H, R_DH);
            7'd32: r = mk(U_ADD, R_T1, R_K3H, R_K3H);
            7'd33: r = mk(U_ADD, R_T0, R_T0, R_T1);
            7'd34: r = mk(U_MUL, R_T0, R_H6, R_T0);
            7'd35: r = mk(U_ADD, R_H, R_H, R_T0);
            7'd36: r = mk(U_ADD, R_T0, R_K1X, R_DX);
            7'd37: r = mk(U_ADD, R_T1, R_K3X, R_K3X);
            7'd38: r = mk(U_ADD, R_T0, R_T0, R_T1);
            7'd39: r = mk(U_MUL, R_T0, R_H6, R_T0);
            7'd40: r = mk(U_ADD, R_X, R_X, R_T0);
            7'd41: r = mk(U_JMP, R_ZERO, 6'd44, R_ZERO);
            7'd42: r = mk(U_ADD, R_H, R_LH, R_ZERO);
            7'd43: r = mk(U_ADD, R_X, R_LX, R_ZERO);
            7'd44: r = mk(U_MUL, R_T0, R_GB, R_X);
            7'd45: r = mk(U_ADD, R_T1, R_T0, R_T0);
            7'd46: r = mk(U_ADD, R_T1, R_T1, R_T0);
            7'd47: r = mk(U_SUB, R_T1, R_IC, R_T1);
            7'd48: r = mk(U_SUB, R_T2, R_GB, R_GA);
            7'd49: r = mk(U_MUL, R_T2, R_T2, R_H);
            7'd50: r = mk(U_ADD, R_THETA, R_T1, R_T2);
            7'd51: r = mk(U_DIV, R_SC, R_THETA, R_MU);
            7'd52: r = mk(U_END, R_ZERO, R_ZERO, R_ZERO);
            7'd53: r = mk(U_SUB, R_T0, R_GA, R_GB);
            7'd54: r = mk(U_MUL, R_T0, R_T0, R_TH);
            7'd55: r = mk(U_ADD, R_T0, R_DRV, R_T0);
            7'd56: r = mk(U_MUL, R_T1, R_GB, R_TX);
            7'd57: r = mk(U_ADD, R_T2, R_T1, R_T1);
            7'd58: r = mk(U_ADD, R_T2, R_T2, R_T1);
            7'd59: r = mk(U_ADD, R_T0, R_T0, R_T2);
            7'd60: r = mk(U_GT, R_ZERO, R_T0, R_IC);
            7'd61: r = mk(U_DIV, R_T1, R_T0, R_IC);
            7'd62: r = mk(U_SUB, R_T1, R_T1, R_ONE);
            7'd63: r = mk(U_SQRT, R_T1, R_T1, R_ZERO);
            7'd64: r = mk(U_MUL, R_T1, R_AX, R_T1);
            7'd65: r = mk(U_SEL, R_T1, R_T1, R_ZERO);
            7'd66: r = mk(U_ADD, R_T2, R_TX, R_TX);
            7'd67: r = mk(U_ADD, R_T2, R_T2, R_TX);
            7'd68: r = mk(U_SUB, R_T2, R_T2, R_TH);
            7'd69: r = mk(U_DIV, R_DH, R_T2, R_TAUH);
            7'd70: r = mk(U_SUB, R_T2, R_T1, R_TX);
            7'd71: r = mk(U_DIV, R_DX, R_T2, R_TAUX);
            7'd72: r = mk(U_RET, R_ZERO, R_ZERO, R_ZERO);
            default: r = mk(U_END, R_ZERO, R_ZERO, R_ZERO);
        endcase
        return r;
    endfunction

endpackage

### hdl/rk4s_regfile.sv
module rk4s_regfile (
    input  logic       aclk,
    input  logic       we,
    input  logic [3:0] waddr,
    input  logic [31:0] wdata,
    input  logic [3:0] raddr_a,
    input  logic [3:0] raddr_b,
    output logic [31:0] rdata_a,
    output logic [31:0] rdata_b
);
    logic [31:0] mem [16];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_a <= mem[raddr_a];
        rdata_b <= mem[raddr_b];
    end
endmodule

### hdl/rk4s_alu.sv
module rk4s_alu (
    input  logic               aclk,
    input  logic               aresetn,
    input  rk4s_pkg::alu_req_t req,
    input  logic [31:0]        a,
    input  logic [31:0]        b,
    output rk4s_pkg::alu_rsp_t rsp,
    output logic [31:0]        result
);
    import rk4s_pkg::*;

    logic        busy_reg;
    logic        done_reg;
    uop_t        op_reg;
    logic [5:0]  cnt_reg;
    logic        neg_reg;
    logic [47:0] num_reg;
    logic [31:0] den_reg;
    logic [31:0] rem_reg;
    logic [47:0] quo_reg;
    logic [23:0] root_reg;
    logic [23:0] bitm_reg;
    logic [31:0] res_reg;

    logic [32:0] sum;
    logic [32:0] diff;
    logic [31:0] ma, mb;
    logic [63:0] prod;
    logic [62:0] sixth_p;
    logic [32:0] rem_sh;
    logic        ge;
    logic [31:0] rem_nx;
    logic [23:0] cand;
    logic [47:0] sq;
    logic        sq_ok;

    always_comb begin
        sum = {a[31], a} + {b[31], b};
        diff = {a[31], a} - {b[31], b};
        ma = a[31] ? 32'(-a) : a;
        mb = b[31] ? 32'(-b) : b;
        prod = 64'(ma) * 64'(mb);
        sixth_p = 63'(a[30:0]) * 63'(SIXTH_M);
        rem_sh = {rem_reg, num_reg[47]};
        ge = rem_sh >= {1'b0, den_reg};
        rem_nx = ge ? 32'(rem_sh - {1'b0, den_reg}) : rem_sh[31:0];
        cand = root_reg | bitm_reg;
        sq = 48'(cand) * 48'(cand);
        sq_ok = sq <= num_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (req.start) begin
                op_reg <= req.op;
                case (req.op)
                    U_ADD: begin
                        res_reg <= (sum[32] != sum[31]) ? (sum[32] ? VMIN : VMAX) : sum[31:0];
                        done_reg <= 1'b1;
                    end
                    U_SUB: begin
                        res_reg <= (diff[32] != diff[31]) ? (diff[32] ? VMIN : VMAX)
                                                            : diff[31:0];
                        done_reg <= 1'b1;
                    end
                    U_MUL: begin
                        res_reg <= sat_mag(prod[63:16], a[31] ^ b[31]);
                        done_reg <= 1'b1;
                    end
                    // The step size is never negative, so both fractions work on a[30:0].
                    U_HALF: begin
                        res_reg <= {1'b0, a[31:1]};
                        done_reg <= 1'b1;
                    end
                    U_SIXTH: begin
                        res_reg <= {3'b000, sixth_p[62:SIXTH_SH]};
                        done_reg <= 1'b1;
                    end
                    U_DIV: begin
                        if (a == '0) begin
                            res_reg <= '0;
                            done_reg <= 1'b1;
                        end else if (b == '0) begin
                            res_reg <= a[31] ? VMIN : VMAX;
                            done_reg <= 1'b1;
                        end else begin
                            busy_reg <= 1'b1;
                            num_reg <= {ma, 16'h0};
                            den_reg <= mb;
                            rem_reg <= '0;
                            quo_reg <= '0;
                            cnt_reg <= 6'd47;
                            neg_reg <= a[31] ^ b[31];
                        end
                    end
                    U_SQRT: begin
                        if (a[31] || a == '0) begin
                            res_reg <= '0;
                            done_reg <= 1'b1;
                        end else begin
                            busy_reg <= 1'b1;
                            num_reg <= {a, 16'h0};
                            root_reg <= '0;
                            bitm_reg <= 24'h800000;
                            cnt_reg <= 6'd23;
                        end
                    end
                    default: begin
                        res_reg <= '0;
                        done_reg <= 1'b1;
                    end
                endcase
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - 6'd1;
                if (op_reg == U_SQRT) begin
                    if (sq_ok) root_reg <= cand;
                    bitm_reg <= bitm_reg >> 1;
                    if (cnt_reg == '0) begin
                        busy_reg <= 1'b0;
                        done_reg <= 1'b1;
                        res_reg <= {8'h0, sq_ok ? cand : root_reg};
                    end
                end else begin
                    rem_reg <= rem_nx;
                    num_reg <= num_reg << 1;
                    quo_reg <= {quo_reg[46:0], ge};
                    if (cnt_reg == '0) begin
                        busy_reg <= 1'b0;
                        done_reg <= 1'b1;
                        res_reg <= sat_mag({quo_reg[46:0], ge}, neg_reg);
                    end
                end
            end
        end
    end

    assign rsp.done = done_reg;
    assign rsp.busy = busy_reg;
    assign result = res_reg;
endmodule

### hdl/modulated_threshold_rk4_step.sv
// Channel   Direction  Handshake            Payload
// s_        in         s_valid / s_ready    cmd, drive_start/mid/end, step_size, load_h/x
// m_        out        m_valid / m_ready    theta_current, scaled_output, h_out, x_out
// apb       in         psel/penable/pready  paddr, pwdata, prdata
// Each of the thirteen divisions of a step item waits on the shared unit, and so does
// each of the four square roots; other arithmetic micro-ops pass through fetch, operand
// read, and execute and write-back, and control micro-ops through fetch and operand read.
// A division with a zero operand skips the iterative loop.
// The next item is taken as soon as the previous result is in the output register, even
// while it waits to be taken. Reset is synchronous and clears the state to zero and the
// registers to 1.0.
module modulated_threshold_rk4_step (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_cmd,
    input  logic [31:0] s_drive_start,
    input  logic [31:0] s_drive_mid,
    input  logic [31:0] s_drive_end,
    input  logic [30:0] s_step_size,
    input  logic [31:0] s_load_h,
    input  logic [31:0] s_load_x,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [31:0] m_theta_current,
    output logic [31:0] m_scaled_output,
    output logic [31:0] m_h_out,
    output logic [31:0] m_x_out,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [rk4s_pkg::APB_AW-1:0] paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import rk4s_pkg::*;

    state_t state_reg, state_next;
    logic [PC_W-1:0] pc_reg, ret_reg;
    logic flag_reg;
    uinstr_t instr;

    logic [31:0] ga_reg, gb_reg;
    logic [30:0] ic_reg, taux_reg, tauh_reg, ax_reg, mu_reg;
    logic [31:0] ds_reg, dm_reg, de_reg, lh_reg, lx_reg;
    logic [30:0] hs_reg;
    logic [31:0] h_reg, x_reg, theta_reg, sc_reg;
    logic        m_valid_reg;
    logic [31:0] m_theta_reg, m_sc_reg, m_h_reg, m_x_reg;

    logic [31:0] rd_a, rd_b, op_a, op_b;
    alu_req_t    alu_req;
    alu_rsp_t    alu_rsp;
    logic [31:0] alu_res;
    logic        wr_en;
    logic [31:0] wr_data;
    logic        accept;
    logic        out_load;
    logic        cfg_we;

    assign instr = rom(pc_reg);
    assign accept = s_valid && s_ready;
    assign out_load = !m_valid_reg || m_ready;
    assign cfg_we = psel && penable && pwrite;

    function automatic logic [31:0] src_val(input logic [5:0] s, input logic [31:0] rd);
        logic [31:0] v;
        case (s)
            R_H: v = h_reg;
            R_X: v = x_reg;
            R_THETA: v = theta_reg;
            R_SC: v = sc_reg;
            R_GA: v = ga_reg;
            R_GB: v = gb_reg;
            R_IC: v = {1'b0, ic_reg};
            R_TAUX: v = {1'b0, taux_reg};
            R_TAUH: v = {1'b0, tauh_reg};
            R_AX: v = {1'b0, ax_reg};
            R_MU: v = {1'b0, mu_reg};
            R_DS: v = ds_reg;
            R_DM: v = dm_reg;
            R_DE: v = de_reg;
            R_HS: v = {1'b0, hs_reg};
            R_LH: v = lh_reg;
            R_LX: v = lx_reg;
            R_ONE: v = ONE;
            R_TWO: v = 32'd2;
            R_SIX: v = 32'd6;
            default: v = (s[5:4] == 2'b00) ? rd : 32'd0;
        endcase
        return v;
    endfunction

    assign op_a = src_val(instr.sa, rd_a);
    assign op_b = src_val(instr.sb, rd_b);

    rk4s_regfile u_rf (
        .aclk    (aclk),
        .we      (wr_en && instr.dst[5:4] == 2'b00),
        .waddr   (instr.dst[3:0]),
        .wdata   (wr_data),
        .raddr_a (instr.sa[3:0]),
        .raddr_b (instr.sb[3:0]),
        .rdata_a (rd_a),
        .rdata_b (rd_b)
    );

    rk4s_alu u_alu (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (alu_req),
        .a       (op_a),
        .b       (op_b),
        .rsp     (alu_rsp),
        .result  (alu_res)
    );

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: if (accept) state_next = S_FETCH;
            S_FETCH: state_next = S_OPER;
            S_OPER: begin
                case (instr.op)
                    U_ADD, U_SUB, U_MUL, U_DIV, U_HALF, U_SIXTH, U_SQRT: state_next = S_WAIT;
                    U_END: state_next = S_DONE;
                    default: state_next = S_FETCH;
                endcase
            end
            S_WAIT: if (alu_rsp.done) state_next = S_FETCH;
            S_DONE: if (out_load) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_comb begin
        s_ready = (state_reg == S_IDLE);
        alu_req.op = instr.op;
        alu_req.start = 1'b0;
        wr_en = 1'b0;
        wr_data = alu_res;
        if (state_reg == S_OPER) begin
            case (instr.op)
                U_ADD, U_SUB, U_MUL, U_DIV, U_HALF, U_SIXTH, U_SQRT: alu_req.start = 1'b1;
                U_SEL: begin
                    wr_en = 1'b1;
                    wr_data = flag_reg ? op_a : 32'd0;
                end
                default: alu_req.start = 1'b0;
            endcase
        end else if (state_reg == S_WAIT && alu_rsp.done) begin
            wr_en = 1'b1;
        end
    end

    // Sequencer, state variables and output register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            pc_reg <= '0;
            ret_reg <= '0;
            flag_reg <= 1'b0;
            h_reg <= '0;
            x_reg <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (accept) begin
                pc_reg <= s_cmd ? PC_LOAD : '0;
            end else if (state_reg == S_OPER) begin
                case (instr.op)
                    U_CALL: begin
                        ret_reg <= pc_reg + 7'd1;
                        pc_reg <= PC_DERIV;
                    end
                    U_RET: pc_reg <= ret_reg;
                    U_JMP: pc_reg <= {1'b0, instr.sa};
                    U_GT, U_SEL: pc_reg <= pc_reg + 7'd1;
                    default: pc_reg <= pc_reg;
                endcase
                if (instr.op == U_GT) flag_reg <= $signed(op_a) > $signed(op_b);
            end else if (state_reg == S_WAIT && alu_rsp.done) begin
                pc_reg <= pc_reg + 7'd1;
            end
            if (wr_en && instr.dst == R_H) h_reg <= wr_data;
            if (wr_en && instr.dst == R_X) x_reg <= wr_data;
            if (state_reg == S_DONE && out_load) m_valid_reg <= 1'b1;
            else if (m_ready) m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en && instr.dst == R_THETA) theta_reg <= wr_data;
        if (wr_en && instr.dst == R_SC) sc_reg <= wr_data;
        if (accept) begin
            ds_reg <= s_drive_start;
            dm_reg <= s_drive_mid;
            de_reg <= s_drive_end;
            hs_reg <= s_step_size;
            lh_reg <= s_load_h;
            lx_reg <= s_load_x;
        end
        if (state_reg == S_DONE && out_load) begin
            m_theta_reg <= theta_reg;
            m_sc_reg <= sc_reg;
            m_h_reg <= h_reg;
            m_x_reg <= x_reg;
        end
    end

    // Configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ga_reg <= ONE;
            gb_reg <= ONE;
            ic_reg <= ONE[30:0];
            taux_reg <= ONE[30:0];
            tauh_reg <= ONE[30:0];
            ax_reg <= ONE[30:0];
            mu_reg <= ONE[30:0];
        end else if (cfg_we) begin
            unique case (paddr[4:2])
                CFG_GAIN_A: ga_reg <= pwdata;
                CFG_GAIN_B: gb_reg <= pwdata;
                CFG_THRESH: ic_reg <= pwdata[30:0];
                CFG_TAU_X: taux_reg <= pwdata[30:0];
                CFG_TAU_H: tauh_reg <= pwdata[30:0];
                CFG_AMP_X: ax_reg <= pwdata[30:0];
                CFG_MU: mu_reg <= pwdata[30:0];
                default: ga_reg <= ga_reg;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[4:2])
            CFG_GAIN_A: prdata = ga_reg;
            CFG_GAIN_B: prdata = gb_reg;
            CFG_THRESH: prdata = {1'b0, ic_reg};
            CFG_TAU_X: prdata = {1'b0, taux_reg};
            CFG_TAU_H: prdata = {1'b0, tauh_reg};
            CFG_AMP_X: prdata = {1'b0, ax_reg};
            CFG_MU: prdata = {1'b0, mu_reg};
            default: prdata = 32'd0;
        endcase
    end

    assign pready = 1'b1;
    assign m_valid = m_valid_reg;
    assign m_theta_current = m_theta_reg;
    assign m_scaled_output = m_sc_reg;
    assign m_h_out = m_h_reg;
    assign m_x_out = m_x_reg;

    // The arithmetic unit only reports completion while the sequencer waits for it.
    a_done_in_wait: assert property (@(posedge aclk) disable iff (!aresetn)
        alu_rsp.done |-> state_reg == S_WAIT)
        else $error("arithmetic unit finished outside of a wait");

    // The program counter never leaves the micro-program.
    a_pc_range: assert property (@(posedge aclk) disable iff (!aresetn)
        pc_reg <= PC_LAST)
        else $error("program counter out of range");

    // An accepted item starts the program, so the block is busy in the next cycle.
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> !s_ready && !alu_rsp.busy)
        else $error("block still ready after taking an item");
endmodule

### verif/tb.sv
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import rk4s_pkg::*;

    localparam longint QMAX = 64'sd2147483647;
    localparam longint QMIN = -64'sd2147483648;
    localparam longint QONE = 64'sd65536;
    localparam int IDLE_LIMIT = 20000;

    typedef enum logic {OP_STEP = 1'b0, OP_LOAD = 1'b1} op_t;

    typedef struct {
        op_t         op;
        logic [31:0] i_start;
        logic [31:0] i_mid;
        logic [31:0] i_end;
        logic [30:0] dt;
        logic [31:0] ld_h;
        logic [31:0] ld_x;
    } item_t;

    typedef struct {
        logic [31:0] theta;
        logic [31:0] scaled;
        logic [31:0] h;
        logic [31:0] x;
    } res_t;

    typedef struct {
        item_t item;
        bit    has_res;
        res_t  res;
    } row_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic        s_cmd = 1'b0;
    logic [31:0] s_drive_start = '0;
    logic [31:0] s_drive_mid = '0;
    logic [31:0] s_drive_end = '0;
    logic [30:0] s_step_size = '0;
    logic [31:0] s_load_h = '0;
    logic [31:0] s_load_x = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [31:0] m_theta_current;
    logic [31:0] m_scaled_output;
    logic [31:0] m_h_out;
    logic [31:0] m_x_out;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [APB_AW-1:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    modulated_threshold_rk4_step u_dut (.*);

    always #5 aclk = ~aclk;

    // Mirror of the neuron's registers and state.
    longint ga, gb, ic, taux, tauh, ax, mu;
    longint hs, xs;

    res_t   expected_q[$];
    int     errors = 0;
    int     idle_cycles = 0;
    bit     hold_off = 1'b0;
    bit     sink_on = 1'b0;

    function automatic longint clamp(longint a);
        return a > QMAX ? QMAX : (a < QMIN ? QMIN : a);
    endfunction

    function automatic longint qadd(longint a, longint b);
        return clamp(a + b);
    endfunction

    function automatic longint qsub(longint a, longint b);
        return clamp(a - b);
    endfunction

    function automatic longint mag_sat(logic [127:0] m, bit neg);
        if (neg) return m > 128'(64'd2147483648) ? QMIN : -longint'(m[63:0]);
        return m > 128'(QMAX) ? QMAX : longint'(m[63:0]);
    endfunction

    function automatic longint qmul(longint a, longint b);
        logic [127:0] p;
        p = 128'(a < 0 ? -a : a) * 128'(b < 0 ? -b : b);
        return mag_sat(p >> 16, (a < 0) != (b < 0));
    endfunction

    function automatic longint qdiv(longint a, longint b);
        logic [127:0] n;
        if (a == 0) return 0;
        if (b == 0) return a > 0 ? QMAX : QMIN;
        n = 128'(a < 0 ? -a : a) << 16;
        return mag_sat(n / 128'(b < 0 ? -b : b), (a < 0) != (b < 0));
    endfunction

    function automatic longint qsqrt(longint r);
        logic [127:0] n, c;
        logic [63:0] acc;
        if (r <= 0) return 0;
        n = 128'(r) << 16;
        acc = 0;
        for (int b = 63; b >= 0; b--) begin
            c = 128'(acc | (64'd1 << b));
            if (c * c <= n) acc = c[63:0];
        end
        return mag_sat(128'(acc), 1'b0);
    endfunction

    function automatic longint x3(longint a);
        return qadd(qadd(a, a), a);
    endfunction

    task automatic slopes(input longint h, input longint x, input longint drv,
                          output longint dh, output longint dx);
        longint ieff, xinf;
        ieff = qadd(qadd(drv, qmul(qsub(ga, gb), h)), x3(qmul(gb, x)));
        xinf = 0;
        if (ieff > ic) xinf = qmul(ax, qsqrt(qsub(qdiv(ieff, ic), QONE)));
        dh = qdiv(qsub(x3(x), h), tauh);
        dx = qdiv(qsub(xinf, x), taux);
    endtask

    task automatic advance_neuron(input item_t it, output res_t r);
        longint i0, im, ie, dt, d2, d6, th, sc;
        longint k1h, k1x, k2h, k2x, k3h, k3x, k4h, k4x, ph, px;
        if (it.op == OP_LOAD) begin
            hs = longint'(signed'(it.ld_h));
            xs = longint'(signed'(it.ld_x));
        end else begin
            i0 = longint'(signed'(it.i_start));
            im = longint'(signed'(it.i_mid));
            ie = longint'(signed'(it.i_end));
            dt = longint'(it.dt);
            d2 = dt / 2;
            d6 = dt / 6;
            slopes(hs, xs, i0, k1h, k1x);
            ph = qadd(hs, qmul(d2, k1h)); px = qadd(xs, qmul(d2, k1x));
            slopes(ph, px, im, k2h, k2x);
            ph = qadd(hs, qmul(d2, k2h)); px = qadd(xs, qmul(d2, k2x));
            slopes(ph, px, im, k3h, k3x);
            ph = qadd(hs, qmul(dt, k3h)); px = qadd(xs, qmul(dt, k3x));
            slopes(ph, px, ie, k4h, k4x);
            k3h = qadd(k3h, k2h); k3x = qadd(k3x, k2x);
            hs = qadd(hs, qmul(d6, qadd(qadd(k1h, k4h), qadd(k3h, k3h))));
            xs = qadd(xs, qmul(d6, qadd(qadd(k1x, k4x), qadd(k3x, k3x))));
        end
        th = qadd(qsub(ic, x3(qmul(gb, xs))), qmul(qsub(gb, ga), hs));
        sc = qdiv(th, mu);
        r.theta = th[31:0];
        r.scaled = sc[31:0];
        r.h = hs[31:0];
        r.x = xs[31:0];
    endtask

    task automatic wait_cycles(input int n);
        repeat (n) @(posedge aclk);
    endtask

    task automatic cfg_write(input logic [2:0] idx, input logic [31:0] val);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= APB_AW'(idx) << 2;
        pwdata <= val;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            CFG_GAIN_A: ga = longint'(signed'(val));
            CFG_GAIN_B: gb = longint'(signed'(val));
            CFG_THRESH: ic = longint'(val[30:0]);
            CFG_TAU_X:  taux = longint'(val[30:0]);
            CFG_TAU_H:  tauh = longint'(val[30:0]);
            CFG_AMP_X:  ax = longint'(val[30:0]);
            CFG_MU:     mu = longint'(val[30:0]);
            default: ;
        endcase
    endtask

    task automatic send_item(input item_t it, input bit has_res, input res_t typed);
        res_t r;
        s_valid <= 1'b1;
        s_cmd <= it.op;
        s_drive_start <= it.i_start;
        s_drive_mid <= it.i_mid;
        s_drive_end <= it.i_end;
        s_step_size <= it.dt;
        s_load_h <= it.ld_h;
        s_load_x <= it.ld_x;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        advance_neuron(it, r);
        if (has_res && r != typed)
            $display("%0t: table row disagrees with prediction", $time);
        expected_q.push_back(has_res ? typed : r);
    endtask

    task automatic send_gap(input item_t it);
        res_t none;
        send_item(it, 1'b0, none);
        if ($urandom_range(0, 3) == 0 || $urandom_range(0, 1) == 0) begin
            int g = $urandom_range(0, 3);
            if (g > 0) begin
                s_valid <= 1'b0;
                wait_cycles(g);
            end
        end
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        while (expected_q.size() > 0) @(posedge aclk);
        wait_cycles(20);
    endtask

    function automatic logic [31:0] rnd_value();
        case ($urandom_range(0, 5))
            0: return $urandom;
            1: return 32'($signed($urandom_range(0, 262143)) - 131072);
            2: return 32'($signed($urandom_range(0, 2097151)) - 1048576);
            3: return 32'h7fffffff - $urandom_range(0, 3);
            4: return 32'h80000000 + $urandom_range(0, 3);
            default: return 32'($signed($urandom_range(0, 65535)) - 32768);
        endcase
    endfunction

    function automatic item_t rnd_item();
        item_t it;
        it.op = ($urandom_range(0, 9) == 0) ? OP_LOAD : OP_STEP;
        it.i_start = rnd_value();
        it.i_mid = rnd_value();
        it.i_end = rnd_value();
        case ($urandom_range(0, 3))
            0: it.dt = 31'($urandom);
            1: it.dt = 31'($urandom_range(0, 65536));
            default: it.dt = 31'($urandom_range(0, 8192));
        endcase
        it.ld_h = rnd_value();
        it.ld_x = rnd_value();
        return it;
    endfunction

    // Result side: compare against the oldest prediction.
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (expected_q.size() == 0) begin
                $display("%0t: result with no item pending: %h %h %h %h", $time,
                         m_theta_current, m_scaled_output, m_h_out, m_x_out);
                errors++;
            end else begin
                res_t e;
                e = expected_q.pop_front();
                if (m_theta_current !== e.theta) begin
                    $display("%0t: theta expected %h actual %h", $time, e.theta,
                             m_theta_current);
                    errors++;
                end
                if (m_scaled_output !== e.scaled) begin
                    $display("%0t: scaled expected %h actual %h", $time, e.scaled,
                             m_scaled_output);
                    errors++;
                end
                if (m_h_out !== e.h) begin
                    $display("%0t: h expected %h actual %h", $time, e.h, m_h_out);
                    errors++;
                end
                if (m_x_out !== e.x) begin
                    $display("%0t: x expected %h actual %h", $time, e.x, m_x_out);
                    errors++;
                end
            end
        end
    end

    // Receiver stalls: random per item, with a long hold-off on request.
    initial begin : sink
        int w;
        wait (sink_on);
        forever begin
            if (hold_off) begin
                m_ready <= 1'b0;
                repeat (6000) @(posedge aclk);
                hold_off = 1'b0;
            end
            w = $urandom_range(0, 3);
            if ($urandom_range(0, 4) == 0) w = 0;
            if (w > 0) begin
                m_ready <= 1'b0;
                wait_cycles(w);
            end
            m_ready <= 1'b1;
            @(posedge aclk);
            while (!(m_valid && m_ready)) @(posedge aclk);
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || psel) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles > IDLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    initial begin
        row_t  dir[$];
        row_t  rw;
        item_t it;
        ga = QONE; gb = QONE; ic = QONE; taux = QONE; tauh = QONE; ax = QONE; mu = QONE;
        hs = 0; xs = 0;
        wait_cycles(11);
        aresetn <= 1'b1;
        @(posedge aclk);
        sink_on = 1'b1;

        // Loads with defaults: theta = 1 - 3X, scaled equals theta.
        rw.has_res = 1'b1;
        rw.item = '{OP_LOAD, 0, 0, 0, 0, 32'h0, 32'h0};
        rw.res = '{32'h00010000, 32'h00010000, 32'h0, 32'h0};
        dir.push_back(rw);
        rw.item = '{OP_LOAD, 0, 0, 0, 0, 32'h7fffffff, 32'h00010000};
        rw.res = '{32'hfffe0000, 32'hfffe0000, 32'h7fffffff, 32'h00010000};
        dir.push_back(rw);
        rw.item = '{OP_LOAD, 0, 0, 0, 0, 32'h80000000, 32'h80000000};
        rw.res = '{32'h7fffffff, 32'h7fffffff, 32'h80000000, 32'h80000000};
        dir.push_back(rw);
        rw.item = '{OP_LOAD, 0, 0, 0, 0, 32'h0, 32'h7fffffff};
        rw.res = '{32'h80010001, 32'h80010001, 32'h0, 32'h7fffffff};
        dir.push_back(rw);
        rw.item = '{OP_LOAD, 0, 0, 0, 0, 32'h0, 32'h0};
        rw.res = '{32'h00010000, 32'h00010000, 32'h0, 32'h0};
        dir.push_back(rw);
        // From rest with zero step the state does not move.
        rw.item = '{OP_STEP, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 0, 0, 0};
        dir.push_back(rw);
        rw.has_res = 1'b0;
        rw.item = '{OP_STEP, 32'h00050000, 32'h00050000, 32'h00050000, 31'h4000, 0, 0};
        dir.push_back(rw);
        rw.item = '{OP_STEP, 32'h7fffffff, 32'h80000000, 32'h7fffffff, 31'h7fffffff, 0, 0};
        dir.push_back(rw);
        rw.item = '{OP_STEP, 32'h80000000, 32'h80000000, 32'h80000000, 31'h10000, 0, 0};
        dir.push_back(rw);
        rw.item = '{OP_STEP, 32'hffffffff, 32'h00010001, 32'h00020000, 31'h5, 0, 0};
        dir.push_back(rw);
        rw.item = '{OP_LOAD, 0, 0, 0, 0, 32'h00008000, 32'hffff0000};
        dir.push_back(rw);
        rw.item = '{OP_STEP, 32'h00200000, 32'h00300000, 32'h00400000, 31'h2000, 0, 0};
        dir.push_back(rw);
        rw.item = '{OP_STEP, 32'h55555555, 32'haaaaaaaa, 32'h12345678, 31'h2aaaaaaa, 0, 0};
        dir.push_back(rw);
        foreach (dir[i]) send_item(dir[i].item, dir[i].has_res, dir[i].res);
        drain();

        // Several register settings, extremes included; random items in each.
        for (int ph = 0; ph < 6; ph++) begin
            case (ph)
                0: begin
                    cfg_write(CFG_GAIN_A, 32'h80000000); cfg_write(CFG_GAIN_B, 32'h7fffffff);
                    cfg_write(CFG_THRESH, 32'h00000001); cfg_write(CFG_TAU_X, 32'h00000001);
                    cfg_write(CFG_TAU_H, 32'h7fffffff); cfg_write(CFG_AMP_X, 32'h00000000);
                    cfg_write(CFG_MU, 32'h00000001);
                end
                1: begin
                    cfg_write(CFG_GAIN_A, 32'h7fffffff); cfg_write(CFG_GAIN_B, 32'h80000000);
                    cfg_write(CFG_THRESH, 32'h7fffffff); cfg_write(CFG_TAU_X, 32'h7fffffff);
                    cfg_write(CFG_TAU_H, 32'h00000001); cfg_write(CFG_AMP_X, 32'h7fffffff);
                    cfg_write(CFG_MU, 32'h7fffffff);
                end
                2: begin
                    // Zero divisors: the low 31 bits of these writes are zero.
                    cfg_write(CFG_GAIN_A, 32'h00008000); cfg_write(CFG_GAIN_B, 32'hffff8000);
                    cfg_write(CFG_THRESH, 32'h80000000); cfg_write(CFG_TAU_X, 32'h80000000);
                    cfg_write(CFG_TAU_H, 32'h00000000); cfg_write(CFG_AMP_X, 32'hffffffff);
                    cfg_write(CFG_MU, 32'h00000000);
                end
                default: begin
                    cfg_write(CFG_GAIN_A, $urandom_range(0, 262143) - 131072);
                    cfg_write(CFG_GAIN_B, $urandom_range(0, 262143) - 131072);
                    cfg_write(CFG_THRESH, $urandom_range(1, 1 << 20));
                    cfg_write(CFG_TAU_X, $urandom_range(1, 1 << 20));
                    cfg_write(CFG_TAU_H, $urandom_range(1, 1 << 20));
                    cfg_write(CFG_AMP_X, $urandom_range(0, 1 << 20));
                    cfg_write(CFG_MU, $urandom_range(1, 1 << 20));
                end
            endcase
            if (ph == 3) hold_off = 1'b1;
            for (int n = 0; n < 200; n++) begin
                it = rnd_item();
                send_gap(it);
            end
            // Sender waits here for every outstanding result.
            drain();
        end

        drain();
        if (errors == 0) $display("Testbench completed without errors");
        else $display("Testbench completed WITH ERRORS");
        $finish;
    end
endmodule

### files.f
hdl/rk4s_pkg.sv
hdl/rk4s_regfile.sv
hdl/rk4s_alu.sv
hdl/modulated_threshold_rk4_step.sv
verif/tb.sv
